// ===== hw/rtl/dksc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package dksc_pkg;

  localparam int unsigned AlphaSize = 59;
  localparam int unsigned IdxW      = 7;   // wide enough for index + 59
  localparam int unsigned CodeW     = 16;
  localparam int unsigned ShiftW    = 4;
  localparam int unsigned KeyPackW  = 64;
  localparam int unsigned KeyCntW   = 5;
  localparam int unsigned KeyPosW   = 4;

  localparam logic [IdxW-1:0] IdxNone = 7'd127;

  typedef enum logic {
    REG_KEY_PACK  = 1'b0,
    REG_KEY_COUNT = 1'b1
  } cfg_reg_e;

  typedef enum logic {
    REQ_ENCRYPT = 1'b0,
    REQ_DECRYPT = 1'b1
  } req_type_e;

  // alphabet index of a code unit, IdxNone if not a letter of the set
  function automatic logic [IdxW-1:0] letter_index(input logic [CodeW-1:0] c);
    logic [CodeW-1:0] d;
    begin
      letter_index = IdxNone;
      if (c >= 16'h0410 && c <= 16'h0415) begin
        d = c - 16'h0410;
        letter_index = d[IdxW-1:0];
      end else if (c == 16'h0401) begin
        letter_index = 7'd6;
      end else if (c >= 16'h0416 && c <= 16'h042F) begin
        d = c - 16'h0416 + 16'd7;
        letter_index = d[IdxW-1:0];
      end else if (c >= 16'h0061 && c <= 16'h007A) begin
        d = c - 16'h0061 + 16'd33;
        letter_index = d[IdxW-1:0];
      end
    end
  endfunction

  // code unit of the letter at alphabet index 0..58
  function automatic logic [CodeW-1:0] letter_code(input logic [IdxW-1:0] idx);
    logic [CodeW-1:0] x;
    begin
      x = {{(CodeW-IdxW){1'b0}}, idx};
      if (idx <= 7'd5) begin
        letter_code = 16'h0410 + x;
      end else if (idx == 7'd6) begin
        letter_code = 16'h0401;
      end else if (idx <= 7'd32) begin
        letter_code = 16'h0416 + x - 16'd7;
      end else begin
        letter_code = 16'h0061 + x - 16'd33;
      end
    end
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/digit_key_shift_cipher.sv =====
`timescale 1ns / 1ps
`default_nettype none

// channel   direction  handshake                 payload
// in        sink       in_valid_i / in_stall_o   in_req_type_i, in_char_code_i, in_message_start_i
// out       source     out_valid_o / out_stall_i out_out_code_o, out_bad_char_o
// cfg       sink       cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// one character per cycle sustained while out_stall_i is low; an input transaction passes through
// the input register, then alphabet lookup and mod-59 shift into the result register
// key position and digit selection happen at the input transaction, so the key
// walk never waits on the output side
// reset: key pack 1, digit count 1, key position 0, both pipeline stages empty
// out_stall_i holds the result register; the input register keeps taking items
// as long as it is empty or the result register can move on

module digit_key_shift_cipher
  import dksc_pkg::*;
#(
  parameter int unsigned MAX_KEY_DIGITS = 16
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  // input character channel
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire logic                in_req_type_i,
  input  wire logic [CodeW-1:0]    in_char_code_i,
  input  wire logic                in_message_start_i,
  // result channel
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output logic [CodeW-1:0]         out_out_code_o,
  output logic                     out_bad_char_o,
  // configuration write channel
  input  wire logic                cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire logic                cfg_index_i,
  input  wire logic [KeyPackW-1:0] cfg_data_i
);

  localparam logic [KeyCntW-1:0] MaxDigits = KeyCntW'(MAX_KEY_DIGITS);

  // configuration registers
  logic [KeyPackW-1:0] key_pack_q;
  logic [KeyCntW-1:0]  key_cnt_q;

  // key walk state
  logic [KeyPosW-1:0]  key_pos_q, key_pos_d;

  // stage 1: captured transaction plus chosen key digit
  logic                s1_v_q;
  logic                s1_dec_q;
  logic [CodeW-1:0]    s1_code_q;
  logic [ShiftW-1:0]   s1_shift_q;

  // stage 2: result register
  logic                out_v_q;
  logic [CodeW-1:0]    out_code_q, out_code_d;
  logic                out_bad_q, out_bad_d;

  logic                in_acc, out_free, s1_move;
  logic [KeyCntW-1:0]  cnt_eff;
  logic [KeyPosW-1:0]  pos_use;
  logic [KeyCntW-1:0]  pos_nxt;
  logic [IdxW-1:0]     idx, sum, res;

  // handshakes
  assign out_free    = !out_v_q || !out_stall_i;
  assign s1_move     = s1_v_q && out_free;
  assign in_stall_o  = s1_v_q && !out_free;
  assign in_acc      = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;

  // digit count clamped to 1..MAX_KEY_DIGITS
  always_comb begin
    cnt_eff = key_cnt_q;
    if (key_cnt_q == '0) cnt_eff = KeyCntW'(1);
    else if (key_cnt_q > MaxDigits) cnt_eff = MaxDigits;
  end

  // key position for this character and for the next one
  always_comb begin
    pos_use = in_message_start_i ? '0 : key_pos_q;
    if ({1'b0, pos_use} >= cnt_eff) pos_use = '0;
    pos_nxt = {1'b0, pos_use} + KeyCntW'(1);
    if (pos_nxt >= cnt_eff) pos_nxt = '0;
    key_pos_d = in_acc ? pos_nxt[KeyPosW-1:0] : key_pos_q;
  end

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_pack_q <= KeyPackW'(1);
      key_cnt_q  <= KeyCntW'(1);
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_KEY_PACK:  key_pack_q <= cfg_data_i;
        REG_KEY_COUNT: key_cnt_q  <= cfg_data_i[KeyCntW-1:0];
        default: ;
      endcase
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_pos_q <= '0;
      s1_v_q    <= 1'b0;
      out_v_q   <= 1'b0;
    end else begin
      key_pos_q <= key_pos_d;
      if (in_acc) s1_v_q <= 1'b1;
      else if (s1_move) s1_v_q <= 1'b0;
      if (s1_move) out_v_q <= 1'b1;
      else if (out_free) out_v_q <= 1'b0;
    end
  end

  // stage 1 payload
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_dec_q   <= in_req_type_i;
      s1_code_q  <= in_char_code_i;
      s1_shift_q <= key_pack_q[pos_use*ShiftW +: ShiftW];
    end
  end

  // alphabet lookup and shift modulo 59, single compare and subtract
  always_comb begin
    idx = letter_index(s1_code_q);
    if (req_type_e'(s1_dec_q) == REQ_DECRYPT) begin
      sum = idx + IdxW'(AlphaSize) - {{(IdxW-ShiftW){1'b0}}, s1_shift_q};
    end else begin
      sum = idx + {{(IdxW-ShiftW){1'b0}}, s1_shift_q};
    end
    res = (sum >= IdxW'(AlphaSize)) ? sum - IdxW'(AlphaSize) : sum;
    if (idx == IdxNone) begin
      out_code_d = '0;
      out_bad_d  = 1'b1;
    end else begin
      out_code_d = letter_code(res);
      out_bad_d  = 1'b0;
    end
  end

  // result register payload
  always_ff @(posedge clk_i) begin
    if (s1_move) begin
      out_code_q <= out_code_d;
      out_bad_q  <= out_bad_d;
    end
  end

  assign out_valid_o    = out_v_q;
  assign out_out_code_o = out_code_q;
  assign out_bad_char_o = out_bad_q;

  // a rejected character always carries a zero code
  a_bad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && out_bad_q |-> out_code_q == '0)
    else $error("bad character with nonzero code");

  // a good character never yields a zero code
  a_good_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && !out_bad_q |-> out_code_q != '0)
    else $error("valid letter mapped to zero code");

  // message start restarts the key walk
  a_msg_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && in_message_start_i |=>
      key_pos_q == (($past(cnt_eff) == KeyCntW'(1)) ? '0 : KeyPosW'(1)))
    else $error("key position not restarted on message start");

  // a blocked stage 1 keeps its transaction
  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_v_q && !out_free |=> s1_v_q && $stable(s1_code_q) && $stable(s1_shift_q))
    else $error("stage 1 lost a transaction while blocked");

  // key position only moves on an input transaction
  a_pos_move: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_acc |=> $stable(key_pos_q))
    else $error("key position changed without a transaction");

endmodule

`default_nettype wire
